/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sdx_pkg.sv */
// ----------------------------------------------------------------------------
// sdx_pkg
// Constants and the letter code table of the Soundex word encoder.
// ----------------------------------------------------------------------------
package sdx_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned DIGIT_SLOTS = 3;
  localparam int unsigned COUNT_W     = 2;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam digit_t DIGIT_ZERO   = 6'd48;
  localparam code_t  CODE_NONE    = 3'd0;
  localparam char_t  CHAR_LOWER_A = 8'd97;
  localparam char_t  CHAR_LOWER_Z = 8'd122;
  localparam count_t COUNT_FULL   = 2'd3;

  // Codes for a .. z; zero marks a letter that is dropped.
  localparam code_t LETTER_CODE [26] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
    3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
  };

  function automatic code_t code_of(char_t c);
    char_t       offs;
    logic [4:0]  idx;
    offs = c - CHAR_LOWER_A;
    idx  = offs[4:0];
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      return LETTER_CODE[idx];
    end
    return CODE_NONE;
  endfunction

  function automatic digit_t to_ascii(code_t code);
    return DIGIT_ZERO + {{(DIGIT_W-CODE_W){1'b0}}, code};
  endfunction

endpackage

/* rtl/soundex_word_encoder.sv */
// ----------------------------------------------------------------------------
// soundex_word_encoder
// Soundex-style phonetic code of a word streamed one character per item.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while in_ready is high. The first character of a word is
// kept as is; later lower-case letters are mapped to digits 1 to 6, with
// vowel-like letters dropped and runs of equal digits merged, and only the
// first three digits are kept. The item marked last produces one result on
// the following cycle: the first character and three ASCII digits, padded
// with '0'. The word state and the letter lookup sit in front of a single
// result register, so in_ready only drops while a finished result waits on
// out_ready; otherwise words can follow each other with no gap.
`include "assert_macros.svh"

module soundex_word_encoder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdx_pkg::char_t  in_character,
  input  logic            in_is_last,
  output logic            out_valid,
  input  logic            out_ready,
  output sdx_pkg::char_t  out_first_letter,
  output sdx_pkg::digit_t out_code_digit_one,
  output sdx_pkg::digit_t out_code_digit_two,
  output sdx_pkg::digit_t out_code_digit_three
);
  import sdx_pkg::*;

  logic   in_word_r,   in_word_nxt;
  char_t  kept_r,      kept_nxt;
  code_t  prev_code_r, prev_code_nxt;
  count_t count_r,     count_nxt;
  code_t  digit_r   [DIGIT_SLOTS];
  code_t  digit_nxt [DIGIT_SLOTS];

  logic   out_valid_r, out_valid_nxt;
  char_t  out_first_r;
  digit_t out_d1_r, out_d2_r, out_d3_r;

  logic   in_fire;
  logic   emit;
  code_t  code;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign emit     = in_fire && in_is_last;
  assign code     = code_of(in_character);

  always_comb begin
    in_word_nxt   = in_word_r;
    kept_nxt      = kept_r;
    prev_code_nxt = prev_code_r;
    count_nxt     = count_r;
    digit_nxt     = digit_r;
    if (in_fire) begin
      if (!in_word_r) begin
        in_word_nxt   = 1'b1;
        kept_nxt      = in_character;
        prev_code_nxt = CODE_NONE;
        count_nxt     = '0;
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
          digit_nxt[i] = CODE_NONE;
        end
      end else if (count_r != COUNT_FULL) begin
        if (code != CODE_NONE && code != prev_code_r) begin
          digit_nxt[count_r] = code;
          count_nxt          = count_r + 2'd1;
        end
        if (code != CODE_NONE) begin
          prev_code_nxt = code;
        end
      end
      if (in_is_last) begin
        in_word_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r   <= 1'b0;
      prev_code_r <= CODE_NONE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
        digit_r[i] <= CODE_NONE;
      end
    end else begin
      in_word_r   <= in_word_nxt;
      prev_code_r <= prev_code_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      digit_r     <= digit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kept_r <= kept_nxt;
    if (emit) begin
      out_first_r <= kept_nxt;
      out_d1_r    <= to_ascii(digit_nxt[0]);
      out_d2_r    <= to_ascii(digit_nxt[1]);
      out_d3_r    <= to_ascii(digit_nxt[2]);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_first_letter     = out_first_r;
  assign out_code_digit_one   = out_d1_r;
  assign out_code_digit_two   = out_d2_r;
  assign out_code_digit_three = out_d3_r;

  // Digits fill in order, so a slot past the count is still empty.
  `SDX_ASSERT_NOW(a_empty_slot, count_r != COUNT_FULL, digit_r[2] == CODE_NONE, "slot past count is not empty")
  // Any collected digit means a previous code is on record.
  `SDX_ASSERT_NOW(a_prev_code, count_r != 2'd0, prev_code_r != CODE_NONE, "digit without previous code")
  // A padded first digit cannot be followed by a real second digit.
  `SDX_ASSERT_NOW(a_pad_order, out_valid_r && out_code_digit_one == DIGIT_ZERO, out_code_digit_two == DIGIT_ZERO, "padding out of order")
  // The last character closes the word and raises a result.
  `SDX_ASSERT_NEXT(a_word_end, emit, out_valid_r && !in_word_r, "last character did not close the word")

endmodule

/* sim/tb_soundex_word_encoder.sv */
// ----------------------------------------------------------------------------
// tb_soundex_word_encoder
// Self-checking bench for the streaming Soundex word encoder.
// ----------------------------------------------------------------------------
// Words are streamed one character per item. A behavioral encoder in this
// bench follows every accepted item and queues the code that each word ends
// with. A monitor compares every returned code field by field. Directed words
// come first, then random words under several sender and receiver idle mixes.
module tb_soundex_word_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import sdx_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTED = 10;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    char_t  first_letter;
    digit_t digit_one;
    digit_t digit_two;
    digit_t digit_three;
  } word_code_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  char_t  in_character = '0;
  logic   in_is_last = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  char_t  out_first_letter;
  digit_t out_code_digit_one;
  digit_t out_code_digit_two;
  digit_t out_code_digit_three;

  // Encoder state tracked by the bench.
  logic   word_open;
  char_t  word_first;
  code_t  last_code;
  int     digits_taken;
  code_t  word_digits [DIGIT_SLOTS];

  word_code_t pending_codes [$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         cycle_count = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;

  soundex_word_encoder i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_character         (in_character),
    .in_is_last           (in_is_last),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_first_letter     (out_first_letter),
    .out_code_digit_one   (out_code_digit_one),
    .out_code_digit_two   (out_code_digit_two),
    .out_code_digit_three (out_code_digit_three)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic code_t letter_digit(char_t c);
    case (c)
      "b", "f", "p", "v":                     return 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": return 3'd2;
      "d", "t":                               return 3'd3;
      "l":                                    return 3'd4;
      "m", "n":                               return 3'd5;
      "r":                                    return 3'd6;
      default:                                return CODE_NONE;
    endcase
  endfunction

  function automatic void clear_word_state();
    last_code    = CODE_NONE;
    digits_taken = 0;
    foreach (word_digits[k]) word_digits[k] = CODE_NONE;
  endfunction

  // Advances the tracked word by one accepted item; a closing item queues
  // the code that the block must return.
  function automatic void encode_char(char_t c, logic last);
    code_t      code;
    word_code_t result;
    if (!word_open) begin
      word_first = c;
      clear_word_state();
      word_open = 1'b1;
    end else if (digits_taken < DIGIT_SLOTS) begin
      code = letter_digit(c);
      if (code != CODE_NONE && code != last_code) begin
        word_digits[digits_taken] = code;
        digits_taken++;
      end
      if (code != CODE_NONE) last_code = code;
    end
    if (last) begin
      result.first_letter = word_first;
      result.digit_one    = DIGIT_ZERO + digit_t'(word_digits[0]);
      result.digit_two    = DIGIT_ZERO + digit_t'(word_digits[1]);
      result.digit_three  = DIGIT_ZERO + digit_t'(word_digits[2]);
      pending_codes = {pending_codes, result};
      word_open = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    word_code_t want;
    word_code_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_first_letter, out_code_digit_one, out_code_digit_two,
               out_code_digit_three};
      if (pending_codes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("%0t: unexpected code %c%c%c%c", $realtime, seen.first_letter,
                   seen.digit_one, seen.digit_two, seen.digit_three);
      end else begin
        want = pending_codes.pop_front();
        if (seen != want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("%0t: code mismatch, expected %h %h %h %h, got %h %h %h %h",
                     $realtime, want.first_letter, want.digit_one, want.digit_two,
                     want.digit_three, seen.first_letter, seen.digit_one,
                     seen.digit_two, seen.digit_three);
        end
      end
    end
  end

  // Offers one item and returns in the time step in which it is accepted,
  // with in_valid still high so that a following item can go out back to back.
  task automatic send_char(char_t c, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    in_is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_char(c, last);
    items_sent++;
  endtask

  task automatic send_word(string w);
    for (int k = 0; k < w.len(); k++) send_char(w[k], k == w.len() - 1);
  endtask

  task automatic test_single_char_words();
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_known_name();
    send_word("Robert");
  endtask

  task automatic test_first_letter_no_merge();
    // The leading b must not absorb the b that follows it.
    send_word("bbf");
  endtask

  task automatic test_ignored_and_long();
    // Bytes outside a..z are skipped, h does not split the two c's, and
    // everything after the third digit is dropped.
    send_char("T", 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h7B, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_word("chczxlqa");
  endtask

  task automatic test_random_words(int budget, int idle_pct, int stall_pct);
    int    start;
    int    tail;
    char_t c;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < budget) begin
      tail = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(8);
      c = ($urandom_range(3) == 0) ? char_t'($urandom_range(255))
                                   : char_t'($urandom_range("Z", "A"));
      send_char(c, tail == 0);
      for (int k = 1; k <= tail; k++) begin
        c = ($urandom_range(9) == 0) ? char_t'($urandom_range(255))
                                     : char_t'($urandom_range(CHAR_LOWER_Z, CHAR_LOWER_A));
        send_char(c, k == tail);
      end
    end
  endtask

  initial begin
    word_open  = 1'b0;
    word_first = '0;
    clear_word_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_char_words();
    test_known_name();
    test_first_letter_no_merge();
    test_ignored_and_long();
    test_random_words(450, 0, 0);
    test_random_words(450, 85, 0);
    test_random_words(450, 0, 85);
    test_random_words(450, 28, 28);

    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_codes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* soundex_word_encoder.f */
+incdir+rtl
rtl/sdx_pkg.sv
rtl/soundex_word_encoder.sv
sim/tb_soundex_word_encoder.sv
